@@ design/heisenberg_matrix_element_defines.svh @@
`ifndef HEISENBERG_MATRIX_ELEMENT_DEFINES_SVH
`define HEISENBERG_MATRIX_ELEMENT_DEFINES_SVH

// same-cycle implication, checked on i_clk outside reset
`define HME_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on i_clk outside reset
`define HME_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/hme_pkg.sv @@
package hme_pkg;

    localparam int C_IN_FIELD_W  = 64;
    localparam int C_TDATA_IN_W  = 128;
    localparam int C_ELEM_W      = 41;
    localparam int C_TDATA_OUT_W = 48;
    localparam int C_TUSER_W     = 3;
    localparam int C_J_W         = 32;
    localparam int C_ND_W        = 2;
    localparam int C_LEN_W       = 7;
    localparam int C_LXY_W       = 13;
    localparam int C_SITES_W     = 19;
    localparam int C_CRD_W       = 6;
    localparam int C_POP_W       = 8;
    localparam int C_EDGE_W      = 9;
    localparam int C_CFG_IDX_W   = 3;
    localparam int C_CFG_DATA_W  = 32;

    localparam logic [C_ND_W-1:0] C_MAX_DIMS = 2'd3;

    localparam logic [C_CFG_IDX_W-1:0] C_REG_NUM_DIMS = 3'd0;
    localparam logic [C_CFG_IDX_W-1:0] C_REG_DIM_X    = 3'd1;
    localparam logic [C_CFG_IDX_W-1:0] C_REG_DIM_Y    = 3'd2;
    localparam logic [C_CFG_IDX_W-1:0] C_REG_DIM_Z    = 3'd3;
    localparam logic [C_CFG_IDX_W-1:0] C_REG_COUPLING = 3'd4;

    typedef enum logic [1:0] {
        K_DIAG = 2'd0,
        K_FLIP = 2'd1,
        K_ZERO = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GEO1,
        S_GEO2,
        S_SCAN,
        S_CALC,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [C_ND_W-1:0]  nd;
        logic [C_LEN_W-1:0] lx;
        logic [C_LEN_W-1:0] ly;
        logic [C_LEN_W-1:0] lz;
        logic [C_LXY_W-1:0] lxy;
    } t_geom;

    typedef struct packed {
        logic [C_CRD_W-1:0] x;
        logic [C_CRD_W-1:0] y;
        logic [C_CRD_W-1:0] z;
    } t_coord;

    typedef struct packed {
        logic                       last;
        logic signed [C_POP_W-1:0]  pop_diff;
        logic [1:0]                 ndiff;
        t_coord                     p;
        t_coord                     q;
        logic signed [C_EDGE_W-1:0] edge_sum;
    } t_scan_stat;

    typedef struct packed {
        logic load;
        logic prep;
        logic step;
    } t_scan_ctrl;

    typedef struct packed {
        logic calc;
        logic load_out;
    } t_res_ctrl;

endpackage

@@ design/heisenberg_matrix_element.sv @@
// Heisenberg spin Hamiltonian matrix element for two spin configurations on a periodic
// lattice of one to three dimensions. One word in gives one word out. Geometry and the
// exchange constant come from the write port and must only change while the block is idle.
// The sites are walked one per cycle through rotating shift registers. Each item passes
// through geometry setup (GEO1, GEO2), the site walk (skipped when the lattice is too
// large), result forming in CALC with a single 32 x 9 multiply, and the hand-off to the
// output register in OUT, which waits until that register is free. A finished
// word waits in the output register while the next input is taken. Output tuser carries
// the element kind (0 diagonal, 1 adjacent flip, 2 zero) and a flag for unequal up-counts
// or a lattice larger than MAX_SITES.
`include "heisenberg_matrix_element_defines.svh"

module heisenberg_matrix_element #(
    parameter int MAX_SITES = 64
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    // [63:0] config_a, [127:64] config_b
    input  logic [hme_pkg::C_TDATA_IN_W-1:0]        i_s_axis_tdata,
    output logic                                    o_m_axis_tvalid,
    input  logic                                    i_m_axis_tready,
    // [40:0] matrix_element, [47:41] zero
    output logic [hme_pkg::C_TDATA_OUT_W-1:0]       o_m_axis_tdata,
    // [1:0] element_kind, [2] bad_input
    output logic [hme_pkg::C_TUSER_W-1:0]           o_m_axis_tuser,
    input  logic                                    i_cfg_wr_en,
    input  logic [hme_pkg::C_CFG_IDX_W-1:0]         i_cfg_addr,
    input  logic [hme_pkg::C_CFG_DATA_W-1:0]        i_cfg_wr_data
);
    import hme_pkg::*;

    t_state                    r_state, n_state;
    logic [C_ND_W-1:0]         r_num_dims;
    logic [C_LEN_W-1:0]        r_dim_x, r_dim_y, r_dim_z;
    logic signed [C_J_W-1:0]   r_coupling;
    t_geom                     r_geom;
    logic                      r_oversize;

    logic [C_ND_W-1:0]         w_nd;
    logic [C_LEN_W-1:0]        w_lx, w_ly, w_lz;
    logic [C_LXY_W-1:0]        w_lxy;
    logic [C_SITES_W-1:0]      w_sites;
    logic                      w_accept, w_out_free;
    t_scan_ctrl                w_scan_ctrl;
    t_res_ctrl                 w_res_ctrl;
    t_scan_stat                w_stat;

    function automatic logic [C_LEN_W-1:0] clamp_len(input logic [C_LEN_W-1:0] v);
        logic [C_LEN_W-1:0] r;
        r = v;
        if (v < C_LEN_W'(2)) begin
            r = C_LEN_W'(2);
        end else if (v > C_LEN_W'(64)) begin
            r = C_LEN_W'(64);
        end
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_dims <= 2'd1;
            r_dim_x    <= 7'd64;
            r_dim_y    <= 7'd2;
            r_dim_z    <= 7'd2;
            r_coupling <= 32'sd65536;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                C_REG_NUM_DIMS: r_num_dims <= i_cfg_wr_data[C_ND_W-1:0];
                C_REG_DIM_X:    r_dim_x    <= i_cfg_wr_data[C_LEN_W-1:0];
                C_REG_DIM_Y:    r_dim_y    <= i_cfg_wr_data[C_LEN_W-1:0];
                C_REG_DIM_Z:    r_dim_z    <= i_cfg_wr_data[C_LEN_W-1:0];
                C_REG_COUPLING: r_coupling <= i_cfg_wr_data;
                default: ;
            endcase
        end
    end

    assign w_nd  = (r_num_dims == '0) ? 2'd1
                 : ((r_num_dims > C_MAX_DIMS) ? C_MAX_DIMS : r_num_dims);
    assign w_lx  = clamp_len(r_dim_x);
    assign w_ly  = (w_nd >= 2'd2) ? clamp_len(r_dim_y) : C_LEN_W'(1);
    assign w_lz  = (w_nd == 2'd3) ? clamp_len(r_dim_z) : C_LEN_W'(1);
    assign w_lxy = w_lx * w_ly;
    assign w_sites = r_geom.lxy * r_geom.lz;

    always_ff @(posedge i_clk) begin
        if (r_state == S_GEO1) begin
            r_geom <= '{nd: w_nd, lx: w_lx, ly: w_ly, lz: w_lz, lxy: w_lxy};
        end
        if (r_state == S_GEO2) begin
            r_oversize <= (w_sites > C_SITES_W'(MAX_SITES));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (w_accept) n_state = S_GEO1;
            S_GEO1: n_state = S_GEO2;
            S_GEO2: n_state = S_SCAN;
            S_SCAN: if (r_oversize || w_stat.last) n_state = S_CALC;
            S_CALC: n_state = S_OUT;
            S_OUT:  if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_s_axis_tready     = 1'b0;
        w_scan_ctrl         = '0;
        w_res_ctrl          = '0;
        case (r_state)
            S_IDLE: begin
                o_s_axis_tready  = 1'b1;
                w_scan_ctrl.load = i_s_axis_tvalid;
            end
            S_GEO2: w_scan_ctrl.prep = 1'b1;
            S_SCAN: w_scan_ctrl.step = !r_oversize;
            S_CALC: w_res_ctrl.calc  = 1'b1;
            S_OUT:  w_res_ctrl.load_out = w_out_free;
            default: ;
        endcase
    end

    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;

    hme_scan #(
        .MAX_SITES (MAX_SITES)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_scan_ctrl),
        .i_a     (i_s_axis_tdata[MAX_SITES-1:0]),
        .i_b     (i_s_axis_tdata[C_IN_FIELD_W+MAX_SITES-1:C_IN_FIELD_W]),
        .i_geom  (r_geom),
        .o_stat  (w_stat)
    );

    hme_result u_result (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctrl          (w_res_ctrl),
        .i_oversize      (r_oversize),
        .i_geom          (r_geom),
        .i_stat          (w_stat),
        .i_coupling      (r_coupling),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_out_free      (w_out_free)
    );

    `HME_ASSERT_NEXT(a_accept_starts, w_accept, r_state == S_GEO1, "accepted word did not start setup")
    `HME_ASSERT_NEXT(a_oversize_skips, (r_state == S_SCAN) && r_oversize, r_state == S_CALC, "oversized lattice was scanned")
    `HME_ASSERT_NEXT(a_out_loads, (r_state == S_OUT) && w_out_free, o_m_axis_tvalid, "free output register not loaded")
    `HME_ASSERT_NOW(a_bad_is_zero, o_m_axis_tvalid && o_m_axis_tuser[2], (o_m_axis_tuser[1:0] == K_ZERO) && (o_m_axis_tdata == '0), "flagged word is not a zero element")

endmodule

@@ design/hme_scan.sv @@
module hme_scan #(
    parameter int MAX_SITES = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  hme_pkg::t_scan_ctrl    i_ctrl,
    input  logic [MAX_SITES-1:0]   i_a,
    input  logic [MAX_SITES-1:0]   i_b,
    input  hme_pkg::t_geom         i_geom,
    output hme_pkg::t_scan_stat    o_stat
);
    import hme_pkg::*;

    localparam int IW = $clog2(MAX_SITES);
    localparam int PW = 20;
    localparam logic [IW-1:0] FWD_X = IW'(1);

    logic [MAX_SITES-1:0]       r_a, r_b;
    logic [IW-1:0]              r_fy, r_fz, r_wx, r_wy, r_wz;
    logic [C_CRD_W-1:0]         r_cx, r_cy, r_cz;
    logic signed [C_POP_W-1:0]  r_pd;
    logic [1:0]                 r_nd;
    t_coord                     r_p, r_q;
    logic signed [C_EDGE_W-1:0] r_es;

    logic [PW-1:0]              w_span_x, w_span_y, w_span_z;
    logic                       w_last_x, w_last_y, w_last_z;
    logic                       w_en_x, w_en_y, w_en_z;
    logic                       w_nb_x, w_nb_y, w_nb_z;
    logic                       w_s, w_d;
    logic signed [C_EDGE_W-1:0] w_delta;
    logic signed [C_POP_W-1:0]  w_pstep;

    function automatic logic signed [C_EDGE_W-1:0] edge_term(input logic en,
                                                             input logic same);
        logic signed [C_EDGE_W-1:0] v;
        v = '0;
        if (en) begin
            v = same ? C_EDGE_W'(1) : -C_EDGE_W'(1);
        end
        return v;
    endfunction

    // distance back to the first site of each dimension's ring
    assign w_span_x = PW'(i_geom.lx) - PW'(1);
    assign w_span_y = PW'(i_geom.lxy) - PW'(i_geom.lx);
    assign w_span_z = PW'((i_geom.lz - C_LEN_W'(1)) * i_geom.lxy);

    assign w_last_x = ({1'b0, r_cx} == i_geom.lx - C_LEN_W'(1));
    assign w_last_y = ({1'b0, r_cy} == i_geom.ly - C_LEN_W'(1));
    assign w_last_z = ({1'b0, r_cz} == i_geom.lz - C_LEN_W'(1));

    // a length-2 ring has one edge, counted from coordinate zero only
    assign w_en_x = (i_geom.lx != C_LEN_W'(2)) || (r_cx == '0);
    assign w_en_y = (i_geom.nd != 2'd1) && ((i_geom.ly != C_LEN_W'(2)) || (r_cy == '0));
    assign w_en_z = (i_geom.nd == 2'd3) && ((i_geom.lz != C_LEN_W'(2)) || (r_cz == '0));

    // r_a is rotated so that the current site sits at bit 0
    assign w_s    = r_a[0];
    assign w_nb_x = w_last_x ? r_a[r_wx] : r_a[FWD_X];
    assign w_nb_y = w_last_y ? r_a[r_wy] : r_a[r_fy];
    assign w_nb_z = w_last_z ? r_a[r_wz] : r_a[r_fz];

    assign w_delta = edge_term(w_en_x, w_s == w_nb_x) + edge_term(w_en_y, w_s == w_nb_y)
                   + edge_term(w_en_z, w_s == w_nb_z);

    assign w_d     = r_a[0] ^ r_b[0];
    assign w_pstep = !w_d ? '0 : (r_a[0] ? C_POP_W'(1) : -C_POP_W'(1));

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_a <= i_a;
            r_b <= i_b;
        end else if (i_ctrl.step) begin
            r_a <= {r_a[0], r_a[MAX_SITES-1:1]};
            r_b <= {r_b[0], r_b[MAX_SITES-1:1]};
        end
        if (i_ctrl.prep) begin
            r_fy <= i_geom.lx[IW-1:0];
            r_fz <= i_geom.lxy[IW-1:0];
            r_wx <= IW'(PW'(MAX_SITES) - w_span_x);
            r_wy <= IW'(PW'(MAX_SITES) - w_span_y);
            r_wz <= IW'(PW'(MAX_SITES) - w_span_z);
        end
        if (i_ctrl.step && w_d) begin
            if (r_nd == 2'd0) begin
                r_p <= '{x: r_cx, y: r_cy, z: r_cz};
            end
            if (r_nd == 2'd1) begin
                r_q <= '{x: r_cx, y: r_cy, z: r_cz};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx <= '0;
            r_cy <= '0;
            r_cz <= '0;
            r_pd <= '0;
            r_nd <= '0;
            r_es <= '0;
        end else if (i_ctrl.prep) begin
            r_cx <= '0;
            r_cy <= '0;
            r_cz <= '0;
            r_pd <= '0;
            r_nd <= '0;
            r_es <= '0;
        end else if (i_ctrl.step) begin
            r_cx <= w_last_x ? '0 : r_cx + C_CRD_W'(1);
            if (w_last_x) begin
                r_cy <= w_last_y ? '0 : r_cy + C_CRD_W'(1);
                if (w_last_y) begin
                    r_cz <= w_last_z ? '0 : r_cz + C_CRD_W'(1);
                end
            end
            r_pd <= r_pd + w_pstep;
            if (w_d && (r_nd != 2'd3)) begin
                r_nd <= r_nd + 2'd1;
            end
            r_es <= r_es + w_delta;
        end
    end

    assign o_stat.last     = w_last_x && w_last_y && w_last_z;
    assign o_stat.pop_diff = r_pd;
    assign o_stat.ndiff    = r_nd;
    assign o_stat.p        = r_p;
    assign o_stat.q        = r_q;
    assign o_stat.edge_sum = r_es;

endmodule

@@ design/hme_result.sv @@
module hme_result (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  hme_pkg::t_res_ctrl                    i_ctrl,
    input  logic                                  i_oversize,
    input  hme_pkg::t_geom                        i_geom,
    input  hme_pkg::t_scan_stat                   i_stat,
    input  logic signed [hme_pkg::C_J_W-1:0]      i_coupling,
    input  logic                                  i_m_axis_tready,
    output logic                                  o_m_axis_tvalid,
    output logic [hme_pkg::C_TDATA_OUT_W-1:0]     o_m_axis_tdata,
    output logic [hme_pkg::C_TUSER_W-1:0]         o_m_axis_tuser,
    output logic                                  o_out_free
);
    import hme_pkg::*;

    logic signed [C_ELEM_W-1:0] r_elem, r_out_elem;
    t_kind                      r_kind, r_out_kind;
    logic                       r_bad, r_out_bad;
    logic                       r_valid;

    logic signed [C_ELEM_W-1:0] w_prod, w_negj, w_diag, w_flip, n_elem;
    t_kind                      n_kind;
    logic                       n_bad;
    logic                       w_dx, w_dy, w_dz, w_one_dim;
    logic [C_CRD_W-1:0]         w_u, w_v;
    logic [C_LEN_W-1:0]         w_len, w_u1, w_v1, w_un, w_vn;
    logic                       w_adj;

    assign w_prod = i_coupling * i_stat.edge_sum;
    // ordered neighbor pairs count every edge twice
    assign w_diag = {w_prod[C_ELEM_W-2:0], 1'b0};
    assign w_negj = -C_ELEM_W'(i_coupling);
    assign w_flip = {w_negj[C_ELEM_W-4:0], 3'b000};

    assign w_dx = (i_stat.p.x != i_stat.q.x);
    assign w_dy = (i_stat.p.y != i_stat.q.y);
    assign w_dz = (i_stat.p.z != i_stat.q.z);
    assign w_one_dim = (w_dx && !w_dy && !w_dz) || (!w_dx && w_dy && !w_dz)
                    || (!w_dx && !w_dy && w_dz);

    always_comb begin
        w_u   = i_stat.p.z;
        w_v   = i_stat.q.z;
        w_len = i_geom.lz;
        if (w_dx) begin
            w_u   = i_stat.p.x;
            w_v   = i_stat.q.x;
            w_len = i_geom.lx;
        end else if (w_dy) begin
            w_u   = i_stat.p.y;
            w_v   = i_stat.q.y;
            w_len = i_geom.ly;
        end
    end

    // ring successor of each coordinate
    assign w_u1  = {1'b0, w_u} + C_LEN_W'(1);
    assign w_v1  = {1'b0, w_v} + C_LEN_W'(1);
    assign w_un  = (w_u1 == w_len) ? '0 : w_u1;
    assign w_vn  = (w_v1 == w_len) ? '0 : w_v1;
    assign w_adj = w_one_dim && ((w_un == {1'b0, w_v}) || (w_vn == {1'b0, w_u}));

    always_comb begin
        n_bad  = 1'b0;
        n_kind = K_ZERO;
        n_elem = '0;
        if (i_oversize || (i_stat.pop_diff != '0)) begin
            n_bad = 1'b1;
        end else if (i_stat.ndiff == 2'd0) begin
            n_kind = K_DIAG;
            n_elem = w_diag;
        end else if ((i_stat.ndiff == 2'd2) && w_adj) begin
            n_kind = K_FLIP;
            n_elem = w_flip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.calc) begin
            r_elem <= n_elem;
            r_kind <= n_kind;
            r_bad  <= n_bad;
        end
        if (i_ctrl.load_out) begin
            r_out_elem <= r_elem;
            r_out_kind <= r_kind;
            r_out_bad  <= r_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.load_out) begin
            r_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    assign o_out_free      = !r_valid || i_m_axis_tready;
    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tdata  = {{(C_TDATA_OUT_W - C_ELEM_W){1'b0}}, r_out_elem};
    assign o_m_axis_tuser  = {r_out_bad, r_out_kind};

endmodule
